[rtl/fbc_pkg.sv]
// ============================================================================
// fbc_pkg: shared types and constants for the frustum box cull block
// Stream field layout, request kinds and the sequencer state type.
// ============================================================================
`default_nettype none

package fbc_pkg;

    // Field widths of one item
    localparam int FIELD_W     = 32;
    localparam int IDX_W       = 3;
    localparam int MASK_BITS   = 6;

    // Slave-side tdata layout, lowest bit up
    localparam int OFS_IDX     = 0;
    localparam int OFS_NX      = 3;
    localparam int OFS_NY      = 35;
    localparam int OFS_NZ      = 67;
    localparam int OFS_D       = 99;
    localparam int OFS_MIN_X   = 131;
    localparam int OFS_MIN_Y   = 163;
    localparam int OFS_MIN_Z   = 195;
    localparam int OFS_MAX_X   = 227;
    localparam int OFS_MAX_Y   = 259;
    localparam int OFS_MAX_Z   = 291;
    localparam int IN_TDATA_W  = 328;

    // Master-side tdata layout, lowest bit up
    localparam int OUT_VIS     = 0;
    localparam int OUT_CONT    = 1;
    localparam int OUT_VIS_NN  = 2;
    localparam int OUT_MASK    = 3;
    localparam int OUT_TDATA_W = 16;

    // Request kinds carried on tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_TEST  = 1'b1;

    // Six products per plane: near x, y, z then far x, y, z
    localparam int          STEP_W    = 3;
    localparam logic [2:0]  STEP_FAR  = 3'd3;
    localparam logic [2:0]  STEP_LAST = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_fbc_state;

endpackage

`default_nettype wire

[rtl/frustum_box_cull.sv]
// ============================================================================
// frustum_box_cull: axis-aligned box test against a table of frustum planes
// Keeps NUM_PLANES planes in Q16.16 and tests boxes against them with one
// shared multiply-accumulate unit.
// ============================================================================
// Usage:
//   Slave channel: tuser = 0 loads one plane (slot plane_index, ignored when
//   out of range) and is done in the accept cycle with no result item.
//   tuser = 1 tests one box and yields one result item on the master channel.
//   Each test walks the planes one product at a time through a single signed
//   COORD_BITS x COORD_BITS multiplier and a wide accumulator: six products
//   per plane (near corner x, y, z, then far corner x, y, z). The result
//   goes from the product register through the result flags into the output
//   register in the done state, and the next item is taken in the cycle after
//   that. Ready is low while a test runs.
//   The output register holds a finished result while the receiver stalls;
//   loads and a new test are still accepted then, and a second test result
//   waits in its final state until the register frees up.
//   Synchronous active-low reset clears all planes to zero (a zero plane
//   never rejects and never contains a box) and empties the output.
// ============================================================================
`default_nettype none

module frustum_box_cull #(
    parameter int NUM_PLANES = 6,
    parameter int COORD_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave: plane_index, normal_x/y/z, plane_offset, box_min_x/y/z,
    //        box_max_x/y/z (low bit up), zero padded
    input  wire logic                            i_s_axis_tvalid,
    output      logic                            o_s_axis_tready,
    input  wire logic [fbc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // slave tuser: req_type
    input  wire logic                            i_s_axis_tuser,
    // master: visible, contained, visible_ignoring_near, reject_mask[5:0]
    //         (low bit up), zero padded
    output      logic                            o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output      logic [fbc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import fbc_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int KW    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int ACC_W = 2 * COORD_BITS + 2;

    // plane table
    logic signed [CB-1:0] r_nx [NUM_PLANES];
    logic signed [CB-1:0] r_ny [NUM_PLANES];
    logic signed [CB-1:0] r_nz [NUM_PLANES];
    logic signed [CB-1:0] r_d  [NUM_PLANES];

    // box under test
    logic signed [CB-1:0] r_lo_x, r_lo_y, r_lo_z;
    logic signed [CB-1:0] r_hi_x, r_hi_y, r_hi_z;

    // sequencer
    t_fbc_state          r_state, n_state;
    logic [KW-1:0]       r_k;
    logic [STEP_W-1:0]   r_step;

    // product stage
    logic                  r_p_valid;
    logic signed [2*CB-1:0] r_prod;
    logic                  r_p_first, r_p_last, r_p_far;
    logic [KW-1:0]         r_p_k;
    logic signed [CB-1:0]  r_p_d;

    // accumulate stage and result flags
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_vis, r_cont, r_vis_nn;
    logic [MASK_BITS-1:0]    r_mask;

    // output register
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;
    logic [OUT_TDATA_W-1:0]  out_word;

    // control
    logic in_acc, load_acc, test_acc, issue, issue_last, out_load;
    logic [IDX_W-1:0] ld_idx;
    logic             ld_ok;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign load_acc = in_acc && (i_s_axis_tuser == REQ_LOAD);
    assign test_acc = in_acc && (i_s_axis_tuser == REQ_TEST);
    assign ld_idx   = i_s_axis_tdata[OFS_IDX +: IDX_W];
    assign ld_ok    = (32'(ld_idx) < 32'(NUM_PLANES));

    assign issue_last = (r_k == KW'(NUM_PLANES - 1)) && (r_step == STEP_LAST);

    // next state and handshake
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        issue           = 1'b0;
        out_load        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (test_acc) n_state = S_RUN;
            end
            S_RUN: begin
                issue = 1'b1;
                if (issue_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // plane table writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_PLANES; j++) begin
                r_nx[j] <= '0;
                r_ny[j] <= '0;
                r_nz[j] <= '0;
                r_d[j]  <= '0;
            end
        end else if (load_acc && ld_ok) begin
            r_nx[KW'(ld_idx)] <= i_s_axis_tdata[OFS_NX +: CB];
            r_ny[KW'(ld_idx)] <= i_s_axis_tdata[OFS_NY +: CB];
            r_nz[KW'(ld_idx)] <= i_s_axis_tdata[OFS_NZ +: CB];
            r_d[KW'(ld_idx)]  <= i_s_axis_tdata[OFS_D  +: CB];
        end
    end

    // operand select: component, corner and plane for this step
    logic                 far_step;
    logic [1:0]           comp;
    logic signed [CB-1:0] sel_n, sel_lo, sel_hi, sel_c;
    logic                 use_hi;
    logic signed [2*CB-1:0] mul_p;

    always_comb begin
        far_step = (r_step >= STEP_FAR);
        comp     = far_step ? 2'(r_step - STEP_FAR) : 2'(r_step);
        unique case (comp)
            2'd0: begin
                sel_n  = r_nx[r_k];
                sel_lo = r_lo_x;
                sel_hi = r_hi_x;
            end
            2'd1: begin
                sel_n  = r_ny[r_k];
                sel_lo = r_lo_y;
                sel_hi = r_hi_y;
            end
            default: begin
                sel_n  = r_nz[r_k];
                sel_lo = r_lo_z;
                sel_hi = r_hi_z;
            end
        endcase
        // nonnegative component: near takes min, far takes max
        use_hi = far_step ? !sel_n[CB-1] : sel_n[CB-1];
        sel_c  = use_hi ? sel_hi : sel_lo;
    end

    // the shared multiplier
    assign mul_p = sel_n * sel_c;

    // accumulate: a sum starts from d scaled to Q32.32
    logic signed [ACC_W-1:0] d_ext, acc_base, acc_sum;
    logic                    sum_neg, sum_zero;

    always_comb begin
        d_ext    = ACC_W'(r_p_d);
        acc_base = r_p_first ? (d_ext <<< 16) : r_acc;
        acc_sum  = acc_base + ACC_W'(r_prod);
        sum_neg  = acc_sum[ACC_W-1];
        sum_zero = (acc_sum == '0);
    end

    // sequencer counters and product-stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_k       <= '0;
            r_step    <= '0;
        end else begin
            r_p_valid <= issue;
            if (test_acc) begin
                r_k    <= '0;
                r_step <= '0;
            end else if (issue) begin
                if (r_step == STEP_LAST) begin
                    r_step <= '0;
                    r_k    <= r_k + KW'(1);
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // box capture
        if (test_acc) begin
            r_lo_x <= i_s_axis_tdata[OFS_MIN_X +: CB];
            r_lo_y <= i_s_axis_tdata[OFS_MIN_Y +: CB];
            r_lo_z <= i_s_axis_tdata[OFS_MIN_Z +: CB];
            r_hi_x <= i_s_axis_tdata[OFS_MAX_X +: CB];
            r_hi_y <= i_s_axis_tdata[OFS_MAX_Y +: CB];
            r_hi_z <= i_s_axis_tdata[OFS_MAX_Z +: CB];
        end
        // product stage
        if (issue) begin
            r_prod    <= mul_p;
            r_p_first <= (r_step == '0) || (r_step == STEP_FAR);
            r_p_last  <= (r_step == (STEP_FAR - 3'd1)) || (r_step == STEP_LAST);
            r_p_far   <= far_step;
            r_p_k     <= r_k;
            r_p_d     <= r_d[r_k];
        end
        // accumulate stage
        if (r_p_valid) begin
            r_acc <= acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis    <= 1'b1;
            r_cont   <= 1'b1;
            r_vis_nn <= 1'b1;
            r_mask   <= '0;
        end else if (test_acc) begin
            r_vis    <= 1'b1;
            r_cont   <= 1'b1;
            r_vis_nn <= 1'b1;
            r_mask   <= '0;
        end else if (r_p_valid && r_p_last) begin
            if (!r_p_far) begin
                if (sum_neg || sum_zero) r_cont <= 1'b0;
            end else if (sum_neg) begin
                r_vis <= 1'b0;
                if (r_p_k != '0) r_vis_nn <= 1'b0;
                for (int j = 0; j < MASK_BITS; j++) begin
                    if (32'(r_p_k) == j) r_mask[j] <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result word, zero padded
    always_comb begin
        out_word                        = '0;
        out_word[OUT_VIS]               = r_vis;
        out_word[OUT_CONT]              = r_cont;
        out_word[OUT_VIS_NN]            = r_vis_nn;
        out_word[OUT_MASK +: MASK_BITS] = r_mask;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_word;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[rtl/fbc_check.sv]
// ============================================================================
// fbc_check: port-level checks for the frustum box cull block
// Watches the stream ports and flags inconsistent results or sequencing.
// ============================================================================
`default_nettype none

module fbc_check (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic                            i_s_axis_tuser,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [fbc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import fbc_pkg::*;

    logic in_acc;
    logic [MASK_BITS-1:0] mask;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign mask   = o_m_axis_tdata[OUT_MASK +: MASK_BITS];

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // a test keeps the block busy on the next cycle
    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_s_axis_tuser == REQ_TEST) |=> !o_s_axis_tready)
        else $error("ready after test accept");

    // a load never creates a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_s_axis_tuser == REQ_LOAD) && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("result after load");

    // rejecting planes and visibility flags agree
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tdata[OUT_VIS] || o_m_axis_tdata[OUT_VIS_NN])
                            && ((mask == '0) || !o_m_axis_tdata[OUT_VIS])
                            && ((mask[MASK_BITS-1:1] == '0) || !o_m_axis_tdata[OUT_VIS_NN]))
        else $error("inconsistent result flags");

endmodule

bind frustum_box_cull fbc_check u_fbc_check (.*);

`default_nettype wire

[tb/sv/frustum_box_cull_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// frustum_box_cull_tb: self-checking bench for the frustum box cull block
// Loads plane tables and streams boxes through the block. Each result item is
// checked field by field against an exact fixed-point model of the six-plane
// test. The receiver and the sender both stall at random.
// ============================================================================

module frustum_box_cull_tb;
    import fbc_pkg::*;

    localparam int PLANE_COUNT = 6;
    localparam int ONE         = 65536;          // 1.0 in Q16.16
    localparam int PHASE_ITEMS = 477;
    localparam int TAIL_CYCLES = 6 * PLANE_COUNT + 24;

    typedef logic signed [FIELD_W-1:0] t_coord;
    typedef logic signed [79:0]        t_wide;

    localparam t_coord MAX32 = 32'sh7fff_ffff;
    localparam t_coord MIN32 = 32'sh8000_0000;

    typedef struct {
        logic             req;
        logic [IDX_W-1:0] idx;
        t_coord           nx, ny, nz, d;
        t_coord           lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
        bit               hold;      // wait for all results before sending
    } t_cull_item;

    typedef struct {
        t_coord nx, ny, nz, d;
    } t_plane;

    typedef struct {
        logic                 visible;
        logic                 contained;
        logic                 vis_nn;
        logic [MASK_BITS-1:0] reject;
    } t_verdict;

    typedef enum {PS_CUBE, PS_LOOSE, PS_WILD}                  t_plane_style;
    typedef enum {BS_ORIGIN, BS_INVERTED, BS_WILD, BS_POINT}   t_box_style;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   m_ready = 1'b0;
    t_cull_item             s_item;
    logic                   s_ready;
    logic                   m_valid;
    logic [IN_TDATA_W-1:0]  s_data;
    logic [OUT_TDATA_W-1:0] m_data;

    t_cull_item pending_q[$];
    t_verdict   verdict_q[$];
    t_plane     plane_tab[PLANE_COUNT];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int tests_sent, loads_sent, results_seen;
    int contained_cnt, rejected_cnt, near_only_cnt;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Item packing
    // ------------------------------------------------------------------------
    function automatic logic [IN_TDATA_W-1:0] pack_item(t_cull_item it);
        logic [IN_TDATA_W-1:0] v;
        v = '0;
        v[OFS_IDX   +: IDX_W]   = it.idx;
        v[OFS_NX    +: FIELD_W] = it.nx;
        v[OFS_NY    +: FIELD_W] = it.ny;
        v[OFS_NZ    +: FIELD_W] = it.nz;
        v[OFS_D     +: FIELD_W] = it.d;
        v[OFS_MIN_X +: FIELD_W] = it.lo_x;
        v[OFS_MIN_Y +: FIELD_W] = it.lo_y;
        v[OFS_MIN_Z +: FIELD_W] = it.lo_z;
        v[OFS_MAX_X +: FIELD_W] = it.hi_x;
        v[OFS_MAX_Y +: FIELD_W] = it.hi_y;
        v[OFS_MAX_Z +: FIELD_W] = it.hi_z;
        return v;
    endfunction

    assign s_data = pack_item(s_item);

    frustum_box_cull #(
        .NUM_PLANES (PLANE_COUNT),
        .COORD_BITS (FIELD_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_item.req),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    // ------------------------------------------------------------------------
    // Exact plane test: sign of n.p + d in Q32.32, no overflow possible
    // ------------------------------------------------------------------------
    function automatic int plane_side(t_plane p, t_coord x, t_coord y, t_coord z);
        t_wide s;
        s = t_wide'(p.nx) * t_wide'(x) + t_wide'(p.ny) * t_wide'(y)
          + t_wide'(p.nz) * t_wide'(z) + (t_wide'(p.d) <<< 16);
        if (s < 0)
            return -1;
        if (s == 0)
            return 0;
        return 1;
    endfunction

    function automatic t_verdict judge_box(t_cull_item it);
        t_verdict v;
        t_plane   p;
        int       near_s, far_s;
        v.visible   = 1'b1;
        v.contained = 1'b1;
        v.vis_nn    = 1'b1;
        v.reject    = '0;
        for (int k = 0; k < PLANE_COUNT; k++) begin
            p = plane_tab[k];
            // negative normal component swaps the corner on that axis
            near_s = plane_side(p, p.nx[FIELD_W-1] ? it.hi_x : it.lo_x,
                                   p.ny[FIELD_W-1] ? it.hi_y : it.lo_y,
                                   p.nz[FIELD_W-1] ? it.hi_z : it.lo_z);
            far_s  = plane_side(p, p.nx[FIELD_W-1] ? it.lo_x : it.hi_x,
                                   p.ny[FIELD_W-1] ? it.lo_y : it.hi_y,
                                   p.nz[FIELD_W-1] ? it.lo_z : it.hi_z);
            if (near_s <= 0)
                v.contained = 1'b0;
            if (far_s < 0) begin
                v.visible = 1'b0;
                if (k != 0)
                    v.vis_nn = 1'b0;
                if (k < MASK_BITS)
                    v.reject[k] = 1'b1;
            end
        end
        return v;
    endfunction

    // Apply one accepted item to the plane table or queue its verdict
    function automatic void absorb_item(t_cull_item it);
        t_verdict v;
        if (it.req == REQ_LOAD) begin
            loads_sent++;
            if (it.idx < PLANE_COUNT)
                plane_tab[it.idx] = '{it.nx, it.ny, it.nz, it.d};
        end else begin
            tests_sent++;
            v = judge_box(it);
            verdict_q.push_back(v);
            if (v.contained)
                contained_cnt++;
            if (!v.visible)
                rejected_cnt++;
            if (!v.visible && v.vis_nn)
                near_only_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic t_coord spread(int mag);
        return t_coord'(int'($urandom_range(0, 2 * mag)) - mag);
    endfunction

    function automatic t_cull_item make_load(int idx, t_coord nx, t_coord ny,
                                             t_coord nz, t_coord d);
        t_cull_item it;
        it.req  = REQ_LOAD;
        it.idx  = idx[IDX_W-1:0];
        it.nx   = nx;
        it.ny   = ny;
        it.nz   = nz;
        it.d    = d;
        it.lo_x = $urandom;
        it.lo_y = $urandom;
        it.lo_z = $urandom;
        it.hi_x = $urandom;
        it.hi_y = $urandom;
        it.hi_z = $urandom;
        it.hold = 1'b0;
        return it;
    endfunction

    function automatic t_cull_item make_test(t_coord lx, t_coord ly, t_coord lz,
                                             t_coord hx, t_coord hy, t_coord hz);
        t_cull_item it;
        it.req  = REQ_TEST;
        it.idx  = IDX_W'($urandom_range(0, 7));
        it.nx   = $urandom;
        it.ny   = $urandom;
        it.nz   = $urandom;
        it.d    = $urandom;
        it.lo_x = lx;
        it.lo_y = ly;
        it.lo_z = lz;
        it.hi_x = hx;
        it.hi_y = hy;
        it.hi_z = hz;
        it.hold = 1'b0;
        return it;
    endfunction

    // Axis-aligned face of a cube frustum: even slots face +axis, odd -axis
    function automatic t_cull_item cube_load(int k, int half, int jitter);
        t_coord n[3];
        int     ax;
        ax = k / 2;
        for (int i = 0; i < 3; i++)
            n[i] = (jitter == 0) ? t_coord'(0) : spread(jitter);
        if (k % 2 == 0)
            n[ax] = t_coord'(ONE + int'($urandom_range(0, jitter)));
        else
            n[ax] = t_coord'(-ONE - int'($urandom_range(0, jitter)));
        return make_load(k, n[0], n[1], n[2], t_coord'(half));
    endfunction

    function automatic t_cull_item make_box(t_box_style st);
        t_coord c[3], h[3], lo[3], hi[3], t;
        int     scale, span;
        case ($urandom_range(0, 2))
            0:       scale = ONE;
            1:       scale = 1 << 20;
            default: scale = 1 << 23;
        endcase
        case ($urandom_range(0, 2))
            0:       span = ONE;
            1:       span = 1 << 20;
            default: span = 1 << 22;
        endcase
        for (int i = 0; i < 3; i++) begin
            c[i]  = spread(scale);
            h[i]  = t_coord'($urandom_range(0, span));
            lo[i] = c[i] - h[i];
            hi[i] = c[i] + h[i];
        end
        case (st)
            BS_INVERTED: begin
                for (int i = 0; i < 3; i++) begin
                    if (i == 0 || $urandom_range(0, 1) == 1) begin
                        t     = lo[i];
                        lo[i] = hi[i];
                        hi[i] = t;
                    end
                end
            end
            BS_WILD: begin
                for (int i = 0; i < 3; i++) begin
                    lo[i] = $urandom;
                    hi[i] = $urandom;
                end
            end
            BS_POINT: begin
                for (int i = 0; i < 3; i++) begin
                    case ($urandom_range(0, 3))
                        0:       lo[i] = MIN32;
                        1:       lo[i] = MAX32;
                        2:       lo[i] = 0;
                        default: lo[i] = spread(1 << 22);
                    endcase
                    hi[i] = lo[i];
                end
            end
            default: ;
        endcase
        return make_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // One fresh table of planes; returns the number of items that count
    function automatic int queue_plane_set();
        t_plane_style style;
        t_cull_item   it;
        int           made, half, pick;
        bit           hold_next;
        made      = 0;
        hold_next = ($urandom_range(0, 3) == 0);
        pick      = $urandom_range(0, 9);
        style     = (pick < 6) ? PS_CUBE : (pick < 9) ? PS_LOOSE : PS_WILD;
        for (int k = 0; k < PLANE_COUNT; k++) begin
            // stray load to a slot that does not exist
            if ($urandom_range(0, 15) == 0) begin
                it      = make_load($urandom_range(PLANE_COUNT, 7), $urandom, $urandom,
                                    $urandom, $urandom);
                it.hold = hold_next;
                hold_next = 1'b0;
                pending_q.push_back(it);
            end
            // occasionally keep the previous plane in this slot
            if ($urandom_range(0, 7) == 0)
                continue;
            case (style)
                PS_CUBE: begin
                    half = $urandom_range(1 << 18, 1 << 22);
                    if ($urandom_range(0, 7) == 0)
                        it = make_load(k, 0, 0, 0,
                                       ($urandom_range(0, 1) == 1) ? t_coord'(0) : spread(ONE));
                    else
                        it = cube_load(k, half, ($urandom_range(0, 1) == 1) ? 2048 : 0);
                end
                PS_LOOSE: it = make_load(k, spread(1 << 17), spread(1 << 17),
                                         spread(1 << 17), spread(1 << 24));
                default:  it = make_load(k, $urandom, $urandom, $urandom, $urandom);
            endcase
            it.hold   = hold_next;
            hold_next = 1'b0;
            pending_q.push_back(it);
            made++;
        end
        return made;
    endfunction

    function automatic void queue_random(int target);
        t_cull_item it;
        int         made, tests, pick;
        made = 0;
        while (made < target) begin
            made += queue_plane_set();
            tests = $urandom_range(3, 24);
            for (int t = 0; t < tests; t++) begin
                // a random load in the middle of a burst of boxes
                if ($urandom_range(0, 19) == 0) begin
                    it = make_load($urandom_range(0, 7), $urandom, $urandom,
                                   $urandom, $urandom);
                    pending_q.push_back(it);
                    if (it.idx < PLANE_COUNT)
                        made++;
                end
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    pending_q.push_back(make_box(BS_ORIGIN));
                else if (pick == 6)
                    pending_q.push_back(make_box(BS_INVERTED));
                else if (pick < 9)
                    pending_q.push_back(make_box(BS_WILD));
                else
                    pending_q.push_back(make_box(BS_POINT));
                made++;
            end
        end
    endfunction

    function automatic void queue_directed();
        t_cull_item it;
        int         a;
        a = 10 * ONE;
        // zero planes after reset: visible, never contained
        pending_q.push_back(make_test(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32));
        // loads beyond the table are dropped
        pending_q.push_back(make_load(6, MAX32, MAX32, MAX32, MIN32));
        pending_q.push_back(make_load(7, MIN32, MIN32, MIN32, MIN32));
        pending_q.push_back(make_test(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        // extreme plane coefficients against extreme and inverted boxes
        pending_q.push_back(make_load(0, MAX32, MIN32, 0, MAX32));
        pending_q.push_back(make_test(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32));
        pending_q.push_back(make_test(MAX32, MAX32, MAX32, MIN32, MIN32, MIN32));
        pending_q.push_back(make_load(0, MIN32, MAX32, -1, MIN32));
        pending_q.push_back(make_test(MIN32, MAX32, 0, MAX32, MAX32, 0));
        // cube frustum of half width 10, sent once the block has drained
        for (int k = 0; k < PLANE_COUNT; k++) begin
            it      = cube_load(k, a, 0);
            it.hold = (k == 0);
            pending_q.push_back(it);
        end
        // fully inside
        pending_q.push_back(make_test(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        // far corner exactly on the near plane: kept, not contained
        pending_q.push_back(make_test(-2 * a, -ONE, -ONE, -a, ONE, ONE));
        // behind the near plane only
        pending_q.push_back(make_test(-3 * a, -ONE, -ONE, -2 * a, ONE, ONE));
        // outside two side planes
        pending_q.push_back(make_test(2 * a, 2 * a, -ONE, 3 * a, 3 * a, ONE));
        // straddling a face
        pending_q.push_back(make_test(-a / 2, -ONE, -ONE, 3 * a / 2, ONE, ONE));
        // min above max
        pending_q.push_back(make_test(a / 2, a / 2, a / 2, -a / 2, -a / 2, -a / 2));
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents pending items, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit slot_free;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            slot_free = !s_valid;
            if (s_valid && s_ready) begin
                absorb_item(s_item);
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (pending_q.size() != 0 && (!pending_q[0].hold || verdict_q.size() == 0)
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_item  <= pending_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result item against the oldest verdict
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected result", m_data, 0);
                end else begin
                    want = verdict_q.pop_front();
                    results_seen++;
                    if (m_data[OUT_VIS] !== want.visible)
                        report_mismatch("visible", m_data[OUT_VIS], want.visible);
                    if (m_data[OUT_CONT] !== want.contained)
                        report_mismatch("contained", m_data[OUT_CONT], want.contained);
                    if (m_data[OUT_VIS_NN] !== want.vis_nn)
                        report_mismatch("visible_ignoring_near", m_data[OUT_VIS_NN],
                                        want.vis_nn);
                    if (m_data[OUT_MASK +: MASK_BITS] !== want.reject)
                        report_mismatch("reject_mask", m_data[OUT_MASK +: MASK_BITS],
                                        want.reject);
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed items, three random phases, drain
    // ------------------------------------------------------------------------
    initial begin
        s_item        = make_test(0, 0, 0, 0, 0, 0);
        s_item.req    = REQ_LOAD;
        for (int k = 0; k < PLANE_COUNT; k++)
            plane_tab[k] = '{0, 0, 0, 0};
        send_idle_pct = 20;
        recv_idle_pct = 68;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        queue_random(PHASE_ITEMS);
        while (pending_q.size() != 0)
            @(posedge i_clk);

        send_idle_pct = 68;
        recv_idle_pct = 20;
        queue_random(PHASE_ITEMS);
        while (pending_q.size() != 0)
            @(posedge i_clk);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(PHASE_ITEMS);
        while (pending_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d plane loads and %0d box tests, %0d results checked",
                 loads_sent, tests_sent, results_seen);
        $display("boxes: %0d fully inside, %0d culled, %0d culled by the near plane alone",
                 contained_cnt, rejected_cnt, near_only_cnt);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[frustum_box_cull.f]
rtl/fbc_pkg.sv
rtl/frustum_box_cull.sv
rtl/fbc_check.sv
tb/sv/frustum_box_cull_tb.sv
